[sv/ffha_pkg.sv]
// shared constants, types and codes for the first-fit heap allocator
package ffha_pkg;

    // heap geometry
    localparam int HEAP_BYTES    = 65536;
    localparam int HEADER_BYTES  = 24;
    localparam int GRANULE_BYTES = 4;
    localparam int OFF_W         = $clog2(HEAP_BYTES) + 1;
    localparam int ADDR_W        = $clog2(HEAP_BYTES / GRANULE_BYTES);
    localparam int DEPTH         = HEAP_BYTES / GRANULE_BYTES;

    localparam logic [OFF_W-1:0] HEAP_MAX = OFF_W'(HEAP_BYTES);
    localparam logic [OFF_W-1:0] HDR      = OFF_W'(HEADER_BYTES);

    // result status codes
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    // block header word
    typedef struct packed {
        logic             free;
        logic [OFF_W-1:0] size;
    } hdr_t;

    // controller states
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_FORMAT = 10'b00_0000_0010,
        S_ARD    = 10'b00_0000_0100,
        S_AEX    = 10'b00_0000_1000,
        S_SPLIT  = 10'b00_0001_0000,
        S_FRD    = 10'b00_0010_0000,
        S_FEX    = 10'b00_0100_0000,
        S_MRD    = 10'b00_1000_0000,
        S_MEX    = 10'b01_0000_0000,
        S_SPARE  = 10'b10_0000_0000
    } state_t;

endpackage

[sv/first_fit_heap_allocator_core.sv]
// first-fit heap allocator core with split on allocate and coalesce on release
//
// Block headers live in one synchronous RAM indexed by header offset / 4; the
// blocks tile the heap, so a walk follows offset + 24 + size from offset 0.
// Each header visited takes a read state and then an examine state, and a walk
// that runs past the last block does the same for the end-of-heap check. An
// allocate walks the blocks up to the first free one that fits, marks it used
// and, when the block is split, writes a free header for the remainder; an
// allocate that finds no fit walks every block and the end check. A release
// walks the blocks up to the one released, then makes a coalesce pass over the
// whole heap and the end check; a release of an offset that is no block
// payload (null included) walks the whole heap and the end check. After
// reset or a write of heap_bytes the core is busy while the single free
// header is written. done pulses for one cycle with status and
// payload_offset; the receiver cannot stall, so results must be taken then.
module first_fit_heap_allocator_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      opcode,
    input  logic [16:0]               request_size,
    input  logic [15:0]               release_offset,
    input  logic                      cfg_we,
    input  logic [16:0]               heap_bytes,
    output logic                      done,
    output ffha_pkg::status_t         status,
    output logic [15:0]               payload_offset
);
    import ffha_pkg::*;

    // header memory
    hdr_t              mem [DEPTH];
    hdr_t              mem_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    hdr_t              mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // control and walk registers
    state_t            state_reg, state_next;
    logic [OFF_W-1:0]  hb_reg, hb_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [15:0]       poff_reg, poff_next;
    logic [OFF_W-1:0]  cur_reg, cur_next;
    logic [OFF_W:0]    need_reg, need_next;
    logic [15:0]       off_reg, off_next;
    logic [OFF_W-1:0]  split_reg, split_next;
    logic [OFF_W-1:0]  head_reg, head_next;
    logic [OFF_W-1:0]  hsize_reg, hsize_next;
    logic              in_run_reg, in_run_next;
    logic              merged_reg, merged_next;

    // derived values of the current header
    logic [OFF_W:0]    cur_end;
    logic              blk_valid;
    logic [OFF_W:0]    next_blk;
    logic              fits;
    logic              do_split;
    logic [OFF_W:0]    split_at;
    logic [OFF_W:0]    hb_mask;
    logic [OFF_W:0]    hsum;

    assign cur_end   = {1'b0, cur_reg} + {1'b0, HDR};
    assign blk_valid = cur_end <= {1'b0, hb_reg};
    assign next_blk  = cur_end + {1'b0, mem_rdata.size};
    assign fits      = mem_rdata.free && ({1'b0, mem_rdata.size} >= need_reg);
    assign do_split  = {2'b00, mem_rdata.size} > ({1'b0, need_reg} + {2'b00, HDR});
    assign split_at  = cur_end + need_reg;
    assign hb_mask   = {1'b0, heap_bytes[16:2], 2'b00};
    assign hsum      = {1'b0, hsize_reg} + {1'b0, HDR} + {1'b0, mem_rdata.size};
    assign mem_raddr = cur_reg[ADDR_W+1:2];

    // header ram, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        hb_next     = hb_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        poff_next   = poff_reg;
        cur_next    = cur_reg;
        need_next   = need_reg;
        off_next    = off_reg;
        split_next  = split_reg;
        head_next   = head_reg;
        hsize_next  = hsize_reg;
        in_run_next = in_run_reg;
        merged_next = merged_reg;
        mem_we      = 1'b0;
        mem_waddr   = cur_reg[ADDR_W+1:2];
        mem_wdata   = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cur_next  = '0;
                    need_next = ({1'b0, request_size} + (OFF_W+1)'(3)) & ~(OFF_W+1)'(3);
                    off_next  = release_offset;
                    state_next = opcode ? S_FRD : S_ARD;
                end
            end
            S_FORMAT:
            begin
                // one free block spanning the heap
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata.free = 1'b1;
                mem_wdata.size = hb_reg - HDR;
                state_next     = S_IDLE;
            end
            S_ARD:
            begin
                state_next = S_AEX;
            end
            S_AEX:
            begin
                if (!blk_valid)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NO_FIT;
                    poff_next   = '0;
                    state_next  = S_IDLE;
                end
                else if (fits)
                begin
                    mem_we         = 1'b1;
                    mem_wdata.free = 1'b0;
                    mem_wdata.size = do_split ? need_reg[OFF_W-1:0] : mem_rdata.size;
                    split_next     = OFF_W'({1'b0, mem_rdata.size} - need_reg
                                            - {1'b0, HDR});
                    status_next    = ST_ALLOCATED;
                    poff_next      = cur_end[15:0];
                    if (do_split)
                    begin
                        state_next = S_SPLIT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cur_next   = next_blk[OFF_W-1:0];
                    state_next = S_ARD;
                end
            end
            S_SPLIT:
            begin
                // free remainder after the allocated payload
                mem_we         = 1'b1;
                mem_waddr      = split_at[ADDR_W+1:2];
                mem_wdata.free = 1'b1;
                mem_wdata.size = split_reg;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_FRD:
            begin
                state_next = S_FEX;
            end
            S_FEX:
            begin
                if (!blk_valid)
                begin
                    done_next   = 1'b1;
                    status_next = ST_IGNORED;
                    poff_next   = '0;
                    state_next  = S_IDLE;
                end
                else if (cur_end == {2'b00, off_reg})
                begin
                    mem_we         = 1'b1;
                    mem_wdata.free = 1'b1;
                    cur_next       = '0;
                    in_run_next    = 1'b0;
                    merged_next    = 1'b0;
                    state_next     = S_MRD;
                end
                else
                begin
                    cur_next   = next_blk[OFF_W-1:0];
                    state_next = S_FRD;
                end
            end
            S_MRD:
            begin
                state_next = S_MEX;
            end
            S_MEX:
            begin
                // coalesce pass: grow the run head, write it back when the run ends
                mem_waddr      = head_reg[ADDR_W+1:2];
                mem_wdata.free = 1'b1;
                mem_wdata.size = hsize_reg;
                if (!blk_valid)
                begin
                    mem_we      = in_run_reg && merged_reg;
                    done_next   = 1'b1;
                    status_next = ST_RELEASED;
                    poff_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (mem_rdata.free)
                    begin
                        if (in_run_reg)
                        begin
                            hsize_next  = hsum[OFF_W-1:0];
                            merged_next = 1'b1;
                        end
                        else
                        begin
                            head_next   = cur_reg;
                            hsize_next  = mem_rdata.size;
                            in_run_next = 1'b1;
                            merged_next = 1'b0;
                        end
                    end
                    else
                    begin
                        mem_we      = in_run_reg && merged_reg;
                        in_run_next = 1'b0;
                    end
                    cur_next   = next_blk[OFF_W-1:0];
                    state_next = S_MRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // heap size write reformats the heap
        if (cfg_we)
        begin
            hb_next    = (hb_mask > {1'b0, HEAP_MAX}) ? HEAP_MAX : hb_mask[OFF_W-1:0];
            state_next = S_FORMAT;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FORMAT;
            hb_reg    <= HEAP_MAX;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hb_reg    <= hb_next;
            done_reg  <= done_next;
        end
    end

    // walk and result registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        poff_reg   <= poff_next;
        cur_reg    <= cur_next;
        need_reg   <= need_next;
        off_reg    <= off_next;
        split_reg  <= split_next;
        head_reg   <= head_next;
        hsize_reg  <= hsize_next;
        in_run_reg <= in_run_next;
        merged_reg <= merged_next;
    end

    // outputs
    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign payload_offset = poff_reg;

endmodule

[sv/ffha_checker.sv]
// port-level checks for the first-fit heap allocator core
module ffha_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              cfg_we,
    input logic              done,
    input ffha_pkg::status_t status,
    input logic [15:0]       payload_offset
);
    import ffha_pkg::*;

    // a result always ends a busy stretch
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // only a successful allocate carries an offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_ALLOCATED) |-> payload_offset == 16'd0)
        else $error("nonzero offset on a non-allocate result");

    // an accepted item keeps the core busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cfg_we |=> busy)
        else $error("accepted item did not raise busy");

    // results never come back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // busy only rises from an item or a heap size write
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) || $past(cfg_we))
        else $error("busy rose without a request");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
